// File: rtl/tcrr_pkg.sv
// ----------------------------------------------------------------------------
// tcrr_pkg
// shared types and codes for the two-class round-robin slot scheduler
// ----------------------------------------------------------------------------
package tcrr_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] action_t;
  typedef logic [1:0] slot_state_t;

  localparam kind_t KIND_SUBMIT = 2'd0;
  localparam kind_t KIND_SCHED  = 2'd1;
  localparam kind_t KIND_FINISH = 2'd2;

  localparam action_t ACT_IDLE   = 3'd0;
  localparam action_t ACT_START  = 3'd1;
  localparam action_t ACT_RESUME = 3'd2;
  localparam action_t ACT_ACCEPT = 3'd3;
  localparam action_t ACT_REFUSE = 3'd4;

  localparam slot_state_t SLOT_FREE    = 2'd0;
  localparam slot_state_t SLOT_PENDING = 2'd1;
  localparam slot_state_t SLOT_RUNNING = 2'd2;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] slot;
  } req_word_t;

  typedef struct packed {
    logic [2:0] chosen_slot;
    action_t    action;
  } rsp_word_t;

endpackage

// File: rtl/two_class_round_robin_slot_scheduler.sv
// ----------------------------------------------------------------------------
// two_class_round_robin_slot_scheduler
// schedule word: scans every slot starting after the current slot, then resolves
// submit/finish word: resolves directly from the addressed slot's state
// the scan reads one slot state per cycle; resolve waits for a free output word
// sync reset: all slots free, current slot 0, no result pending
// ----------------------------------------------------------------------------
module two_class_round_robin_slot_scheduler #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  tcrr_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output tcrr_pkg::rsp_word_t rsp
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int EW = (IW > 3) ? IW : 3;
  localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SCAN    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_t;

  state_t                st;
  tcrr_pkg::kind_t       kind_r;
  logic [2:0]            slot_r;
  logic [IW-1:0]         ptr;
  logic [IW-1:0]         cnt;
  logic                  pend_hit;
  logic [IW-1:0]         pend_idx;
  logic                  run_hit;
  logic [IW-1:0]         run_idx;
  logic [IW-1:0]         current_slot;

  logic [IW-1:0]         inc_src;
  logic [IW-1:0]         inc_out;
  logic [IW-1:0]         rd_addr;
  tcrr_pkg::slot_state_t rd_data;
  logic [IW-1:0]         slot_idx;
  logic                  in_range;
  logic                  out_free;
  logic                  load;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  tcrr_pkg::slot_state_t wr_data;
  logic [IW-1:0]         sel_idx;
  logic [EW-1:0]         sel_ext;
  logic [IW-1:0]         current_next;
  tcrr_pkg::rsp_word_t   res;

  // shared wrap-around incrementer
  assign inc_src  = (st == ST_IDLE) ? current_slot : ptr;
  assign inc_out  = (inc_src == LAST) ? '0 : inc_src + 1'b1;

  assign slot_idx = IW'(slot_r);
  assign in_range = (32'(slot_r) < 32'(SLOT_COUNT));
  assign rd_addr  = (st == ST_SCAN) ? ptr : slot_idx;

  assign req_stall = (st != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign load      = (st == ST_RESOLVE) && out_free;

  tcrr_slot_table #(
    .DEPTH (SLOT_COUNT),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign sel_idx = pend_hit ? pend_idx : (run_hit ? run_idx : '0);
  assign sel_ext = EW'(sel_idx);

  always_comb begin
    res.chosen_slot = slot_r;
    res.action      = tcrr_pkg::ACT_REFUSE;
    wr_en           = 1'b0;
    wr_addr         = slot_idx;
    wr_data         = tcrr_pkg::SLOT_FREE;
    current_next    = current_slot;
    unique case (kind_r)
      tcrr_pkg::KIND_SCHED: begin
        res.chosen_slot = sel_ext[2:0];
        current_next    = sel_idx;
        if (pend_hit) begin
          res.action = tcrr_pkg::ACT_START;
          wr_en      = 1'b1;
          wr_addr    = pend_idx;
          wr_data    = tcrr_pkg::SLOT_RUNNING;
        end else if (run_hit) begin
          res.action = tcrr_pkg::ACT_RESUME;
        end else begin
          res.action = tcrr_pkg::ACT_IDLE;
        end
      end
      tcrr_pkg::KIND_SUBMIT: begin
        if (in_range && rd_data == tcrr_pkg::SLOT_FREE) begin
          res.action = tcrr_pkg::ACT_ACCEPT;
          wr_en      = 1'b1;
          wr_data    = tcrr_pkg::SLOT_PENDING;
        end
      end
      tcrr_pkg::KIND_FINISH: begin
        if (in_range && rd_data == tcrr_pkg::SLOT_RUNNING) begin
          res.action = tcrr_pkg::ACT_ACCEPT;
          wr_en      = 1'b1;
          wr_data    = tcrr_pkg::SLOT_FREE;
        end
      end
      default: begin
        res.action = tcrr_pkg::ACT_REFUSE;
      end
    endcase
    if (!load) begin
      wr_en = 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      current_slot <= '0;
      pend_hit     <= 1'b0;
      run_hit      <= 1'b0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (req_valid) begin
            kind_r   <= req.kind;
            slot_r   <= req.slot;
            ptr      <= inc_out;
            cnt      <= '0;
            pend_hit <= 1'b0;
            run_hit  <= 1'b0;
            st       <= (req.kind == tcrr_pkg::KIND_SCHED) ? ST_SCAN : ST_RESOLVE;
          end
        end
        ST_SCAN: begin
          if (!pend_hit && rd_data == tcrr_pkg::SLOT_PENDING) begin
            pend_hit <= 1'b1;
            pend_idx <= ptr;
          end
          if (!run_hit && rd_data == tcrr_pkg::SLOT_RUNNING) begin
            run_hit <= 1'b1;
            run_idx <= ptr;
          end
          ptr <= inc_out;
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            st <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          if (out_free) begin
            current_slot <= current_next;
            st           <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_current_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(current_slot) < 32'(SLOT_COUNT))
    else $error("current slot out of range");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SCAN) |-> (32'(ptr) < 32'(SLOT_COUNT)))
    else $error("scan pointer out of range");

  a_load_from_resolve: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(st == ST_RESOLVE))
    else $error("result word loaded outside resolve");

  a_sched_hit_order: assert property (@(posedge clk) disable iff (rst)
    (load && kind_r == tcrr_pkg::KIND_SCHED && res.action == tcrr_pkg::ACT_IDLE)
      |=> (current_slot == '0))
    else $error("idle schedule did not clear current slot");
`endif

endmodule

// File: rtl/tcrr_slot_table.sv
// ----------------------------------------------------------------------------
// tcrr_slot_table
// per-slot state table, one read port and one write port, cleared by reset
// ----------------------------------------------------------------------------
module tcrr_slot_table #(
  parameter int DEPTH = 8,
  parameter int IW    = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IW-1:0]        rd_addr,
  output tcrr_pkg::slot_state_t rd_data,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_addr,
  input  tcrr_pkg::slot_state_t wr_data
);

  tcrr_pkg::slot_state_t slots [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        slots[i] <= tcrr_pkg::SLOT_FREE;
      end
    end else if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
  end

  assign rd_data = slots[rd_addr];

endmodule
